// ===== rtl/core/jcst_pkg.sv =====
// Shared types and fixed field widths for the jump chain shortcut table.
// No dependencies; imported by the top level and the remainder unit.
`timescale 1ns / 1ps
`default_nettype none

package jcst_pkg;

	// Fixed widths of the external fields
	localparam int unsigned CMD_W   = 1;
	localparam int unsigned POS_W   = 10;
	localparam int unsigned LEN_W   = 11;
	localparam int unsigned HOPS_W  = 11;
	localparam int unsigned COUNT_W = 11;

	localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET = 11'd1024;

	typedef enum logic [CMD_W-1:0] {
		CMD_SET   = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REM,
		ST_SET_EVAL,
		ST_SET_MERGE,
		ST_QRY_HOP,
		ST_QRY_OUT
	} state_t;

	// Start and finish strobes of the serial remainder unit
	typedef struct packed {
		logic start;
		logic done;
	} rem_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/jcst_rem.sv =====
// Remainder of a position by the fixed block size, by reciprocal multiplication.
// Depends on jcst_pkg for the start/done strobe struct.
`timescale 1ns / 1ps
`default_nettype none

module jcst_rem
	import jcst_pkg::*;
#(
	parameter int unsigned DIVISOR = 32,
	parameter int unsigned DW      = 10
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire rem_ctl_t                     ctl_in,
	output rem_ctl_t                          ctl_out,
	input  wire logic [DW-1:0]                dividend,
	output logic      [$clog2(DIVISOR)-1:0]   remainder
);

	localparam int unsigned RW = $clog2(DIVISOR);
	localparam int unsigned SH = DW + RW;
	localparam int unsigned MW = DW + 2;
	localparam int unsigned PW = DW + MW;
	// ceil(2^SH / DIVISOR): exact quotient for every DW-bit dividend
	localparam longint unsigned RECIP =
		((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

	logic [DW-1:0] dvd_q;
	logic [DW-1:0] quo_q;
	logic [RW-1:0] rem_q;
	logic          run_q;
	logic          done_q;
	logic [PW-1:0] prod;
	logic [DW-1:0] quo;
	logic [DW-1:0] back;

	// quotient in the take cycle, remainder in the next
	always_comb begin
		prod = PW'(dividend) * PW'(RECIP);
		quo  = DW'(prod >> SH);
		back = quo_q * DW'(DIVISOR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			run_q  <= ctl_in.start;
			done_q <= run_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			dvd_q <= dividend;
			quo_q <= quo;
		end
		if (run_q) begin
			rem_q <= RW'(dvd_q - back);
		end
	end

	always_comb begin
		ctl_out.start = run_q;
		ctl_out.done  = done_q;
		remainder     = rem_q;
	end

endmodule

`default_nettype wire

// ===== rtl/core/jump_chain_shortcut_table.sv =====
// Jump chain table with per-block shortcuts: jump memory, shortcut memory, control.
// Depends on jcst_pkg and the remainder unit jcst_rem.
`timescale 1ns / 1ps
`default_nettype none

// Channel      Dir   Handshake             Payload
// -----------  ----  --------------------  ---------------------------------
// input item   in    in_valid / in_stall   cmd, position, jump_length
// result       out   out_valid / out_stall last_position, hop_count
// config       in    cfg_we                cfg_wdata (entry_count)
//
// Set: take the transfer, get the block offset from the remainder unit,
// then refresh up to BLOCK_SIZE entries, from the position down to the
// block start. An entry whose jump leaves the block is written at once;
// one whose jump stays inside reads the shortcut memory, then writes back.
// Query: take the transfer, follow shortcuts (one shortcut memory read each,
// its data feeding the next address), then finish into the output register.
// Reset clears control state and sets entry_count to 1024; memories are not
// cleared. A result held by out_stall does not block taking the next item;
// a query that finishes while the output register is full waits for it.

module jump_chain_shortcut_table
	import jcst_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES = 1024,
	parameter int unsigned BLOCK_SIZE  = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration
	input  wire logic                cfg_we,
	input  wire logic [COUNT_W-1:0]  cfg_wdata,
	// input items
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [CMD_W-1:0]    cmd,
	input  wire logic [POS_W-1:0]    position,
	input  wire logic [LEN_W-1:0]    jump_length,
	// results
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [POS_W-1:0]         last_position,
	output logic [HOPS_W-1:0]        hop_count
);

	localparam int unsigned AW  = $clog2(MAX_ENTRIES);
	localparam int unsigned CW  = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned TW  = ((AW > LEN_W) ? AW : LEN_W) + 1;
	localparam int unsigned HW  = $clog2(BLOCK_SIZE + 1);
	localparam int unsigned RMW = $clog2(BLOCK_SIZE);

	// shortcut entry: first exit beyond the block, last in-block position, hops
	typedef struct packed {
		logic [CW-1:0] exit_pos;
		logic [AW-1:0] last_pos;
		logic [HW-1:0] hops;
	} sc_entry_t;

	// memories
	logic [LEN_W-1:0] jump_store_q     [MAX_ENTRIES];
	sc_entry_t        shortcut_store_q [MAX_ENTRIES];
	logic [LEN_W-1:0] jump_rd_q;
	sc_entry_t        sc_rd_q;

	// control and working registers
	state_t             state_q, state_d;
	logic [COUNT_W-1:0] entry_count_q;
	logic [AW-1:0]      i_q;
	logic [AW-1:0]      start_q;
	logic [TW-1:0]      end_q;
	logic [LEN_W-1:0]   len_q;
	logic               first_q;
	logic [AW-1:0]      j_q;
	logic [HOPS_W-1:0]  hops_q;
	logic [AW-1:0]      last_q;
	logic               out_valid_q;
	logic [POS_W-1:0]   last_position_q;
	logic [HOPS_W-1:0]  hop_count_q;

	// combinational
	logic [CW-1:0]    n;
	logic             accept;
	logic             pos_ok;
	logic             take_set;
	logic             take_qry;
	logic [LEN_W-1:0] len_fix;
	logic [LEN_W-1:0] cur_jump;
	logic [TW-1:0]    target;
	logic             in_block;
	logic [AW-1:0]    blk_start;
	logic             out_free;
	logic             qry_stop;

	logic       sc_we;
	sc_entry_t  sc_wdata;
	logic       sc_re;
	logic [AW-1:0] sc_raddr;
	logic       jm_re;
	logic       i_dec;
	logic       set_bounds;
	logic       hop_upd;
	logic       load_out;

	rem_ctl_t        rem_ctl_in, rem_ctl_out;
	logic [RMW-1:0]  rem_val;

	// Clamp the entry count into 1..MAX_ENTRIES
	always_comb begin
		if (entry_count_q == '0) begin
			n = CW'(1);
		end else if (32'(entry_count_q) > 32'(MAX_ENTRIES)) begin
			n = CW'(MAX_ENTRIES);
		end else begin
			n = CW'(entry_count_q);
		end
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
		accept   = in_valid & ~in_stall;
		pos_ok   = 32'(position) < 32'(n);
		take_set = accept & pos_ok & (cmd_t'(cmd) == CMD_SET);
		take_qry = accept & pos_ok & (cmd_t'(cmd) == CMD_QUERY);
		len_fix  = (jump_length == '0) ? LEN_W'(1) : jump_length;
		out_free = ~out_valid_q | ~out_stall;

		// the first refreshed entry takes the new length straight from the transfer
		cur_jump = first_q ? len_q : jump_rd_q;
		target   = TW'(i_q) + TW'(cur_jump);
		in_block = (target < end_q) && (target < TW'(n));

		blk_start = i_q - AW'(rem_val);

		// walk ends when the shortcut leaves the table or fails to advance
		qry_stop = (sc_rd_q.exit_pos <= CW'(j_q)) || (sc_rd_q.exit_pos >= n);
	end

	always_comb begin
		rem_ctl_in.start = take_set;
		rem_ctl_in.done  = 1'b0;
	end

	jcst_rem #(
		.DIVISOR (BLOCK_SIZE),
		.DW      (AW)
	) u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_in    (rem_ctl_in),
		.ctl_out   (rem_ctl_out),
		.dividend  (AW'(position)),
		.remainder (rem_val)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and strobes
	always_comb begin
		state_d    = state_q;
		sc_we      = 1'b0;
		sc_wdata   = sc_rd_q;
		sc_re      = 1'b0;
		sc_raddr   = AW'(position);
		jm_re      = 1'b0;
		i_dec      = 1'b0;
		set_bounds = 1'b0;
		hop_upd    = 1'b0;
		load_out   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (take_set) begin
					state_d = ST_REM;
				end else if (take_qry) begin
					sc_re   = 1'b1;
					state_d = ST_QRY_HOP;
				end
			end
			ST_REM: begin
				if (rem_ctl_out.done) begin
					set_bounds = 1'b1;
					state_d    = ST_SET_EVAL;
				end
			end
			ST_SET_EVAL: begin
				if (in_block) begin
					// fetch the shortcut of the in-block target
					sc_re    = 1'b1;
					sc_raddr = AW'(target);
					state_d  = ST_SET_MERGE;
				end else begin
					sc_we             = 1'b1;
					sc_wdata.exit_pos = (target < TW'(n)) ? CW'(target) : n;
					sc_wdata.last_pos = i_q;
					sc_wdata.hops     = HW'(1);
					if (i_q == start_q) begin
						state_d = ST_IDLE;
					end else begin
						jm_re = 1'b1;
						i_dec = 1'b1;
					end
				end
			end
			ST_SET_MERGE: begin
				sc_we             = 1'b1;
				sc_wdata.exit_pos = sc_rd_q.exit_pos;
				sc_wdata.last_pos = sc_rd_q.last_pos;
				sc_wdata.hops     = sc_rd_q.hops + HW'(1);
				if (i_q == start_q) begin
					state_d = ST_IDLE;
				end else begin
					jm_re   = 1'b1;
					i_dec   = 1'b1;
					state_d = ST_SET_EVAL;
				end
			end
			ST_QRY_HOP: begin
				hop_upd = 1'b1;
				if (qry_stop) begin
					state_d = ST_QRY_OUT;
				end else begin
					sc_re    = 1'b1;
					sc_raddr = AW'(sc_rd_q.exit_pos);
				end
			end
			ST_QRY_OUT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= ENTRY_COUNT_RESET;
		end else if (cfg_we) begin
			entry_count_q <= cfg_wdata;
		end
	end

	// jump memory: written on a set transfer, read one entry below the cursor
	always_ff @(posedge clk) begin
		if (take_set) begin
			jump_store_q[AW'(position)] <= len_fix;
		end
		if (jm_re) begin
			jump_rd_q <= jump_store_q[i_q - AW'(1)];
		end
	end

	// shortcut memory: written at the cursor, read at the chosen address
	always_ff @(posedge clk) begin
		if (sc_we) begin
			shortcut_store_q[i_q] <= sc_wdata;
		end
		if (sc_re) begin
			sc_rd_q <= shortcut_store_q[sc_raddr];
		end
	end

	// set cursor and block bounds
	always_ff @(posedge clk) begin
		if (take_set) begin
			i_q   <= AW'(position);
			len_q <= len_fix;
		end else if (i_dec) begin
			i_q <= i_q - AW'(1);
		end
		if (set_bounds) begin
			start_q <= blk_start;
			end_q   <= TW'(blk_start) + TW'(BLOCK_SIZE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b0;
		end else if (take_set) begin
			first_q <= 1'b1;
		end else if (i_dec) begin
			first_q <= 1'b0;
		end
	end

	// query accumulators
	always_ff @(posedge clk) begin
		if (take_qry) begin
			j_q    <= AW'(position);
			hops_q <= '0;
			last_q <= AW'(position);
		end else if (hop_upd) begin
			j_q    <= AW'(sc_rd_q.exit_pos);
			hops_q <= hops_q + HOPS_W'(sc_rd_q.hops);
			last_q <= sc_rd_q.last_pos;
		end
	end

	// output register: hold while stalled, drop once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			last_position_q <= POS_W'(last_q);
			hop_count_q     <= hops_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign last_position = last_position_q;
	assign hop_count     = hop_count_q;

endmodule

`default_nettype wire
